>>> hdl/u64da_pkg.sv
// ----------------------------------------------------------------------------
// u64da_pkg
// Shared widths, constants and types for the 64-bit to decimal ASCII converter.
// ----------------------------------------------------------------------------
package u64da_pkg;

   localparam int VALUE_W     = 64;
   localparam int CAP_W       = 16;
   localparam int DIGITS      = 20;
   localparam int BCD_W       = 4 * DIGITS;
   localparam int COUNT_W     = 5;
   localparam int CHAR_W      = 6;
   localparam int SHIFT_CNT_W = $clog2(VALUE_W);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = 1;
   localparam int QFILL_W     = 2;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // one converted item handed from the converter to the emitter
   typedef struct packed {
      logic [BCD_W-1:0]   bcd;
      logic [COUNT_W-1:0] count;
      logic               too_small;
   } entry_type;

   // queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> hdl/u64da_req_if.sv
// ----------------------------------------------------------------------------
// u64da_req_if
// Request channel: value to convert and destination capacity.
// ----------------------------------------------------------------------------
interface u64da_req_if;
   import u64da_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [CAP_W-1:0]   buffer_size;

   modport source (output valid, output value, output buffer_size, input ready);
   modport sink   (input valid, input value, input buffer_size, output ready);

endinterface

>>> hdl/u64da_rsp_if.sv
// ----------------------------------------------------------------------------
// u64da_rsp_if
// Response channel: one ASCII digit or one error item per transfer.
// ----------------------------------------------------------------------------
interface u64da_rsp_if;
   import u64da_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  digit_char;
   logic [COUNT_W-1:0] digit_count;
   logic               too_small;
   logic               last;

   modport source (output valid, output digit_char, output digit_count,
                   output too_small, output last, input ready);
   modport sink   (input valid, input digit_char, input digit_count,
                   input too_small, input last, output ready);

endinterface

>>> hdl/u64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii
// Converts an unsigned 64-bit value to decimal ASCII digits, or flags an
// undersized destination buffer.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_ch  | in        | value, buffer_size
//  rsp_ch  | out       | digit_char, digit_count, too_small, last
//
// an item occupies the converter through a load, 64 double dabble shift steps
// and a hand over; the bit-serial converter sets the rate. digits leave at one
// per cycle while rsp_ch is ready and overlap the next conversion.
// synchronous reset clears the sequencer, queue pointers and digit position.
// a stalled rsp_ch fills the two-entry queue, after which req_ch holds off.
// ----------------------------------------------------------------------------
module u64_to_decimal_ascii
   import u64da_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u64da_req_if.sink   req_ch,
   u64da_rsp_if.source rsp_ch
);

   logic         push_valid;
   logic         push_ready;
   entry_type    push_entry;
   entry_type    head;
   q_status_type status;
   logic         pop;

   // converter
   u64da_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // handoff queue
   u64da_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   // emitter
   u64da_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

`ifndef ASSERT_OFF
   // an error item is always the only one
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.too_small |-> rsp_ch.last)
      else $error("error item without last");

   // digits are ASCII decimal when no error
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.too_small |->
         (rsp_ch.digit_char >= 6'd48) && (rsp_ch.digit_char <= 6'd57))
      else $error("digit outside ascii range");

   // converter is busy after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("converter took a second item too early");

   // a popped entry leaves no full queue behind when nothing was pushed
   a_pop_frees: assert property (@(posedge clock) disable iff (reset)
      pop && !(push_valid && push_ready) |=> !status.full)
      else $error("queue still full after pop");
`endif

endmodule

>>> hdl/u64da_front.sv
// ----------------------------------------------------------------------------
// u64da_front
// Bit-serial double dabble converter; counts digits and checks capacity.
// ----------------------------------------------------------------------------
module u64da_front
   import u64da_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   u64da_req_if.sink  req_ch,
   output logic       push_valid,
   output entry_type  push_entry,
   input  logic       push_ready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_PUSH  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [SHIFT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]     val_ff, val_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [COUNT_W-1:0]     count;

   assign req_ch.ready = (state_ff == S_IDLE);

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // position of the highest non-zero digit gives the count
   always_comb begin
      count = COUNT_W'(1);
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            count = COUNT_W'(i + 1);
         end
      end
   end

   assign push_valid           = (state_ff == S_PUSH);
   assign push_entry.bcd       = bcd_ff;
   assign push_entry.count     = count;
   assign push_entry.too_small = (cap_ff < (CAP_W'(count) + CAP_W'(1)));

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      cap_in   = cap_ff;
      bcd_in   = bcd_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               val_in   = req_ch.value;
               cap_in   = req_ch.buffer_size;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            bcd_in = {bcd_adj[BCD_W-2:0], val_ff[VALUE_W-1]};
            val_in = {val_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + SHIFT_CNT_W'(1);
            if (cnt_ff == SHIFT_CNT_W'(VALUE_W - 1)) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      val_ff <= val_in;
      cap_ff <= cap_in;
      bcd_ff <= bcd_in;
   end

endmodule

>>> hdl/u64da_queue.sv
// ----------------------------------------------------------------------------
// u64da_queue
// Two-entry queue between the converter and the emitter.
// ----------------------------------------------------------------------------
module u64da_queue
   import u64da_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  entry_type    push_entry,
   output logic         push_ready,
   input  logic         pop,
   output entry_type    head,
   output q_status_type status
);

   entry_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (fill_ff == QFILL_W'(QDEPTH));
   assign status.empty = (fill_ff == '0);
   assign push_ready   = !status.full;
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      fill_in   = fill_ff + QFILL_W'(do_push) - QFILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/u64da_back.sv
// ----------------------------------------------------------------------------
// u64da_back
// Emitter: sends the digits of the head entry, most significant first.
// ----------------------------------------------------------------------------
module u64da_back
   import u64da_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head,
   input  q_status_type status,
   output logic         pop,
   u64da_rsp_if.source  rsp_ch
);

   logic [COUNT_W-1:0] pos_ff, pos_in;
   logic [COUNT_W-1:0] digit_idx;
   logic [3:0]         digit;
   logic               is_last;
   logic               take;

   // digit position counted down from the most significant
   assign digit_idx = head.count - COUNT_W'(1) - pos_ff;
   assign digit     = head.bcd[{digit_idx, 2'b00} +: 4];
   assign is_last   = head.too_small || (pos_ff == (head.count - COUNT_W'(1)));

   assign rsp_ch.valid       = !status.empty;
   assign rsp_ch.digit_char  = head.too_small ? '0 : (ASCII_ZERO + CHAR_W'(digit));
   assign rsp_ch.digit_count = head.count;
   assign rsp_ch.too_small   = head.too_small;
   assign rsp_ch.last        = is_last;

   assign take = rsp_ch.valid && rsp_ch.ready;
   assign pop  = take && is_last;

   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         pos_in = is_last ? '0 : (pos_ff + COUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
